// ===== sv/sound_speed_profile_interpolator_assert.svh =====
// Assertion macros for the interpolator RTL; used by the controller.
// No dependencies; taken in by `include where a module asserts.
`ifndef SOUND_SPEED_PROFILE_INTERPOLATOR_ASSERT_SVH
`define SOUND_SPEED_PROFILE_INTERPOLATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSPI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sspi assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SSPI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sspi assertion failed");

`endif

// ===== sv/sspi_pkg.sv =====
// Types and constants of the sound speed profile interpolator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package sspi_pkg;

   localparam int DEPTH_W     = 21;
   localparam int SPEED_W     = 21;
   localparam int WEIGHT_W    = 21;
   localparam int WCNT_W      = 3;
   localparam int COEF_W      = 16;
   localparam int NUM_COEFS   = 4;
   localparam int ACC_W       = 32;
   localparam int PROD_W      = WEIGHT_W + COEF_W;
   localparam int NUM_W       = 54;
   localparam int DIV_CNT_W   = 6;
   localparam int RES_W       = 23;
   localparam int SPEED_LIMIT = 4000000;
   localparam int SCNT_W      = 7;
   localparam int CCNT_W      = 3;
   localparam int ADDR_W      = 5;
   localparam int DATA_W      = 32;

   localparam logic [2:0] CSR_SAMPLE_COUNT = 3'd0;
   localparam logic [2:0] CSR_COEF_COUNT   = 3'd1;
   localparam logic [2:0] CSR_COEF_ZERO    = 3'd2;
   localparam logic [2:0] CSR_COEF_ONE     = 3'd3;
   localparam logic [2:0] CSR_COEF_TWO     = 3'd4;
   localparam logic [2:0] CSR_COEF_THREE   = 3'd5;

   localparam logic [1:0] MODE_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_WEIGHT = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_COR_RD, S_COR_BASE, S_W_RD, S_W_MUL,
      S_W_ACC, S_COR_END, S_PREP, S_IMUL, S_DIV_GO, S_DIV_WAIT, S_MISS, S_DONE
   } state_type;

   typedef struct packed {
      logic [SCNT_W-1:0]                    sample_count;
      logic [CCNT_W-1:0]                    coef_count;
      logic [NUM_COEFS-1:0][COEF_W-1:0]     coef;
   } cfg_type;

   typedef struct packed {
      logic wr_sample;
      logic wr_weight;
      logic load_query;
      logic depth_rd;
      logic scan_step;
      logic hit_load;
      logic end_rd;
      logic base_load;
      logic w_rd;
      logic w_mul;
      logic w_acc;
      logic end_done;
      logic prep;
      logic imul;
      logic div_start;
      logic res_up;
      logic res_div;
      logic res_miss;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic idx_zero;
      logic hit;
      logic last;
      logic n_lt2;
      logic nlim_zero;
      logic j_last;
      logic end_sel;
      logic depth_eq;
      logic div_done;
   } status_type;

endpackage

// ===== sv/sspi_div.sv =====
// Serial restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on sspi_pkg.
`timescale 1ns / 1ps
module sspi_div import sspi_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic [DEPTH_W-1:0]      den,
   output logic                    done,
   output logic signed [NUM_W:0]   quot
);
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]     q_ff, q_in;
   logic [DEPTH_W:0]     rem_ff, rem_in;
   logic [DEPTH_W-1:0]   den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic [DEPTH_W:0]     rem_sh;
   logic                 ge;

   always_comb begin
      rem_sh  = {rem_ff[DEPTH_W-1:0], q_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(NUM_W);
         neg_in  = num[NUM_W-1];
         q_in    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         q_in   = {q_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
endmodule

// ===== sv/sspi_dp.sv =====
// Datapath: profile table memories, scan compare, shape correction MAC,
// interpolation multiply, divider and result registers. Depends on sspi_pkg, sspi_div.
`timescale 1ns / 1ps
module sspi_dp import sspi_pkg::*; #(
   parameter int MAX_SAMPLES = 64,
   parameter int MAX_WEIGHTS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   input  cfg_type                     cfg,
   input  logic [5:0]                  req_entry_index,
   input  logic [1:0]                  req_weight_index,
   input  logic [DEPTH_W-1:0]          req_depth_value,
   input  logic [SPEED_W-1:0]          req_speed_value,
   input  logic [WCNT_W-1:0]           req_weight_count,
   input  logic signed [WEIGHT_W-1:0]  req_weight_value,
   output status_type                  status,
   output logic signed [RES_W-1:0]     rsp_speed_result,
   output logic                        rsp_found
);
   localparam int AW    = $clog2(MAX_SAMPLES);
   localparam int CW    = $clog2(MAX_SAMPLES + 1);
   localparam int WDEP  = MAX_SAMPLES * MAX_WEIGHTS;
   localparam int WAW   = (WDEP > 1) ? $clog2(WDEP) : 1;
   localparam int LIM   = (MAX_WEIGHTS < NUM_COEFS) ? MAX_WEIGHTS : NUM_COEFS;
   localparam int SUM_W = NUM_W + 2;

   logic [DEPTH_W-1:0]         depth_mem  [MAX_SAMPLES];
   logic [SPEED_W-1:0]         speed_mem  [MAX_SAMPLES];
   logic [WCNT_W-1:0]          wcnt_mem   [MAX_SAMPLES];
   logic [WEIGHT_W-1:0]        weight_mem [WDEP];

   logic [DEPTH_W-1:0]         depth_q, speed_q;
   logic [WCNT_W-1:0]          wcnt_q;
   logic signed [WEIGHT_W-1:0] w_q;

   logic [DEPTH_W-1:0]         query_ff, prev_ff, d0_ff, d1_ff;
   logic [AW-1:0]              idx_ff, lo_ff, end_ff;
   logic                       end_sel_ff;
   logic [WCNT_W-1:0]          j_ff, nlim_ff, nlim;
   logic signed [ACC_W-1:0]    acc_ff, up_ff, dn_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic [DEPTH_W-1:0]         dq_ff, den_ff;
   logic signed [ACC_W:0]      dd_ff;
   logic signed [NUM_W-1:0]    num_ff;
   logic signed [RES_W-1:0]    res_ff, rsp_res_ff;
   logic                       found_ff, rsp_found_ff;
   logic [CW-1:0]              n_use;
   logic [WAW-1:0]             wr_waddr, rd_waddr;
   logic                       div_done;
   logic signed [NUM_W:0]      quot;
   logic signed [SUM_W-1:0]    sum, sum_sel;
   logic signed [RES_W-1:0]    sat;
   logic [WCNT_W-1:0]          m1;

   always_comb begin
      n_use = (32'(cfg.sample_count) > MAX_SAMPLES) ? CW'(MAX_SAMPLES)
                                                    : CW'(cfg.sample_count);
      wr_waddr = WAW'(AW'(req_entry_index)) * WAW'(MAX_WEIGHTS) + WAW'(req_weight_index);
      rd_waddr = WAW'(end_ff) * WAW'(MAX_WEIGHTS) + WAW'(j_ff);
      m1   = (wcnt_q < cfg.coef_count) ? wcnt_q : cfg.coef_count;
      nlim = (m1 < WCNT_W'(LIM)) ? m1 : WCNT_W'(LIM);
   end

   // table writes happen only while idle; reads are registered
   always_ff @(posedge clock) begin
      if (cmd.wr_sample && (32'(req_entry_index) < MAX_SAMPLES)) begin
         depth_mem[AW'(req_entry_index)] <= req_depth_value;
         speed_mem[AW'(req_entry_index)] <= req_speed_value;
         wcnt_mem[AW'(req_entry_index)]  <= req_weight_count;
      end
      if (cmd.wr_weight && (32'(req_entry_index) < MAX_SAMPLES)
          && (32'(req_weight_index) < MAX_WEIGHTS)) begin
         weight_mem[wr_waddr] <= req_weight_value;
      end
      if (cmd.depth_rd) depth_q <= depth_mem[idx_ff];
      if (cmd.end_rd) begin
         speed_q <= speed_mem[end_ff];
         wcnt_q  <= wcnt_mem[end_ff];
      end
      if (cmd.w_rd) w_q <= weight_mem[rd_waddr];
   end

   sspi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      sum_sel = cmd.res_div ? SUM_W'(quot) : '0;
      sum     = SUM_W'(up_ff) + sum_sel;
      if (sum > SUM_W'(SPEED_LIMIT))       sat = RES_W'(SPEED_LIMIT);
      else if (sum < -SUM_W'(SPEED_LIMIT)) sat = -RES_W'(SPEED_LIMIT);
      else                                 sat = RES_W'(sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         end_sel_ff <= 1'b0;
         j_ff       <= '0;
      end else begin
         if (cmd.load_query) idx_ff <= '0;
         else if (cmd.scan_step) idx_ff <= idx_ff + 1'b1;
         if (cmd.hit_load) end_sel_ff <= 1'b0;
         else if (cmd.end_done) end_sel_ff <= 1'b1;
         if (cmd.base_load) j_ff <= '0;
         else if (cmd.w_acc) j_ff <= j_ff + 1'b1;
      end
      if (cmd.load_query) query_ff <= req_depth_value;
      if (cmd.scan_step) prev_ff <= depth_q;
      if (cmd.hit_load) begin
         d0_ff  <= prev_ff;
         d1_ff  <= depth_q;
         lo_ff  <= idx_ff - 1'b1;
         end_ff <= idx_ff - 1'b1;
      end
      if (cmd.base_load) begin
         acc_ff  <= ACC_W'(speed_q);
         nlim_ff <= nlim;
      end
      if (cmd.w_mul) prod_ff <= PROD_W'(w_q) * PROD_W'($signed(cfg.coef[j_ff[1:0]]));
      if (cmd.w_acc) acc_ff <= acc_ff + ACC_W'(prod_ff >>> 8);
      if (cmd.end_done) begin
         if (!end_sel_ff) begin
            up_ff  <= acc_ff;
            end_ff <= lo_ff + 1'b1;
         end else begin
            dn_ff <= acc_ff;
         end
      end
      if (cmd.prep) begin
         dq_ff  <= query_ff - d0_ff;
         den_ff <= d1_ff - d0_ff;
         dd_ff  <= (ACC_W+1)'(dn_ff) - (ACC_W+1)'(up_ff);
      end
      // widen both operands so the full product is kept
      if (cmd.imul) num_ff <= NUM_W'($signed({1'b0, dq_ff})) * NUM_W'(dd_ff);
      if (cmd.res_up || cmd.res_div) begin
         res_ff   <= sat;
         found_ff <= 1'b1;
      end else if (cmd.res_miss) begin
         res_ff   <= '0;
         found_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_res_ff   <= res_ff;
         rsp_found_ff <= found_ff;
      end
   end

   always_comb begin
      status.idx_zero  = idx_ff == '0;
      status.hit       = (query_ff >= prev_ff) && (query_ff <= depth_q);
      status.last      = CW'(idx_ff) == n_use - 1'b1;
      status.n_lt2     = n_use < CW'(2);
      status.nlim_zero = nlim == '0;
      status.j_last    = (j_ff + 1'b1) == nlim_ff;
      status.end_sel   = end_sel_ff;
      status.depth_eq  = d0_ff == d1_ff;
      status.div_done  = div_done;
   end

   assign rsp_speed_result = rsp_res_ff;
   assign rsp_found        = rsp_found_ff;
endmodule

// ===== sv/sspi_ctrl.sv =====
// Controller state machine: sequences writes, table scan, corrections,
// interpolation and the result handshake. Depends on sspi_pkg and the assert header.
`timescale 1ns / 1ps
`include "sound_speed_profile_interpolator_assert.svh"
module sspi_ctrl import sspi_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_mode)
                  MODE_SAMPLE: cmd.wr_sample = 1'b1;
                  MODE_WEIGHT: cmd.wr_weight = 1'b1;
                  MODE_QUERY: begin
                     cmd.load_query = 1'b1;
                     state_in = status.n_lt2 ? S_MISS : S_SCAN_RD;
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN_RD: begin
            cmd.depth_rd = 1'b1;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            priority if (status.idx_zero) begin
               cmd.scan_step = 1'b1;
               state_in = S_SCAN_RD;
            end else if (status.hit) begin
               cmd.hit_load = 1'b1;
               state_in = S_COR_RD;
            end else if (status.last) begin
               state_in = S_MISS;
            end else begin
               cmd.scan_step = 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_COR_RD: begin
            cmd.end_rd = 1'b1;
            state_in = S_COR_BASE;
         end
         S_COR_BASE: begin
            cmd.base_load = 1'b1;
            state_in = status.nlim_zero ? S_COR_END : S_W_RD;
         end
         S_W_RD: begin
            cmd.w_rd = 1'b1;
            state_in = S_W_MUL;
         end
         S_W_MUL: begin
            cmd.w_mul = 1'b1;
            state_in = S_W_ACC;
         end
         S_W_ACC: begin
            cmd.w_acc = 1'b1;
            state_in = status.j_last ? S_COR_END : S_W_RD;
         end
         S_COR_END: begin
            cmd.end_done = 1'b1;
            state_in = status.end_sel ? S_PREP : S_COR_RD;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            if (status.depth_eq) begin
               cmd.res_up = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_IMUL;
            end
         end
         S_IMUL: begin
            cmd.imul = 1'b1;
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.res_div = 1'b1;
               state_in = S_DONE;
            end
         end
         S_MISS: begin
            cmd.res_miss = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;

   `SSPI_ASSERT_NOW(a_rsp_slot_free, clock, reset, cmd.rsp_load, !rsp_valid_ff || rsp_ready)
   `SSPI_ASSERT_NEXT(a_div_wait, clock, reset, cmd.div_start, state_ff == S_DIV_WAIT)
   `SSPI_ASSERT_NEXT(a_query_leaves_idle, clock, reset, cmd.load_query,
                     state_ff == S_SCAN_RD || state_ff == S_MISS)
   `SSPI_ASSERT_NOW(a_one_result_src, clock, reset, cmd.res_div || cmd.res_up,
                    !cmd.res_miss)
endmodule

// ===== sv/sound_speed_profile_interpolator.sv =====
// Sound speed profile interpolator top level: configuration registers,
// controller and datapath. Depends on sspi_pkg, sspi_ctrl, sspi_dp.
`timescale 1ns / 1ps
// Write items (sample or shape weight) are accepted in the idle state, one per
// cycle. A query scans the table one sample at a time (registered depth memory
// read, then compare), computes the shape correction of both interval ends on
// the single multiply-accumulate unit (per end a table read and base load, then
// a read, multiply and accumulate for each used weight), then, unless the two
// end depths are equal, runs the serial divider at one quotient bit per cycle.
// The result stays in an output register, so the next item is accepted while
// it waits to be taken.
module sound_speed_profile_interpolator import sspi_pkg::*; #(
   parameter int MAX_SAMPLES = 64,
   parameter int MAX_WEIGHTS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_mode,
   input  logic [5:0]                  req_entry_index,
   input  logic [1:0]                  req_weight_index,
   input  logic [DEPTH_W-1:0]          req_depth_value,
   input  logic [SPEED_W-1:0]          req_speed_value,
   input  logic [WCNT_W-1:0]           req_weight_count,
   input  logic signed [WEIGHT_W-1:0]  req_weight_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [RES_W-1:0]     rsp_speed_result,
   output logic                        rsp_found,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ADDR_W-1:0]           paddr,
   input  logic [DATA_W-1:0]           pwdata,
   output logic [DATA_W-1:0]           prdata,
   output logic                        pready
);
   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;
   logic [2:0] reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (reg_sel)
            CSR_SAMPLE_COUNT: cfg_in.sample_count = pwdata[SCNT_W-1:0];
            CSR_COEF_COUNT:   cfg_in.coef_count   = pwdata[CCNT_W-1:0];
            CSR_COEF_ZERO:    cfg_in.coef[0]      = pwdata[COEF_W-1:0];
            CSR_COEF_ONE:     cfg_in.coef[1]      = pwdata[COEF_W-1:0];
            CSR_COEF_TWO:     cfg_in.coef[2]      = pwdata[COEF_W-1:0];
            CSR_COEF_THREE:   cfg_in.coef[3]      = pwdata[COEF_W-1:0];
            default: ;
         endcase
      end
      unique case (reg_sel)
         CSR_SAMPLE_COUNT: prdata = DATA_W'(cfg_ff.sample_count);
         CSR_COEF_COUNT:   prdata = DATA_W'(cfg_ff.coef_count);
         CSR_COEF_ZERO:    prdata = DATA_W'(cfg_ff.coef[0]);
         CSR_COEF_ONE:     prdata = DATA_W'(cfg_ff.coef[1]);
         CSR_COEF_TWO:     prdata = DATA_W'(cfg_ff.coef[2]);
         CSR_COEF_THREE:   prdata = DATA_W'(cfg_ff.coef[3]);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else       cfg_ff <= cfg_in;
   end

   sspi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sspi_dp #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .MAX_WEIGHTS (MAX_WEIGHTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cfg              (cfg_ff),
      .req_entry_index  (req_entry_index),
      .req_weight_index (req_weight_index),
      .req_depth_value  (req_depth_value),
      .req_speed_value  (req_speed_value),
      .req_weight_count (req_weight_count),
      .req_weight_value (req_weight_value),
      .status           (status),
      .rsp_speed_result (rsp_speed_result),
      .rsp_found        (rsp_found)
   );
endmodule

// ===== dv/tb_sound_speed_profile_interpolator.sv =====
// Self-checking testbench for the sound speed profile interpolator.
// Depends on sspi_pkg and sound_speed_profile_interpolator; APB set-up, random stimulus.
`timescale 1ns / 1ps
module tb_sound_speed_profile_interpolator;
   import sspi_pkg::*;

   typedef struct {
      logic [1:0]                 mode;
      logic [5:0]                 entry;
      logic [1:0]                 widx;
      logic [DEPTH_W-1:0]         depth;
      logic [SPEED_W-1:0]         speed;
      logic [WCNT_W-1:0]          wcnt;
      logic signed [WEIGHT_W-1:0] wval;
   } req_item_t;

   typedef struct {
      logic signed [RES_W-1:0] speed;
      logic                    found;
   } rsp_item_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_mode = '0;
   logic [5:0] req_entry_index = '0;
   logic [1:0] req_weight_index = '0;
   logic [DEPTH_W-1:0] req_depth_value = '0;
   logic [SPEED_W-1:0] req_speed_value = '0;
   logic [WCNT_W-1:0] req_weight_count = '0;
   logic signed [WEIGHT_W-1:0] req_weight_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [RES_W-1:0] rsp_speed_result;
   logic rsp_found;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;

   sound_speed_profile_interpolator uut (.*);

   always #10 clock = ~clock;

   // predictor state
   logic [DEPTH_W-1:0]  prof_depth [64];
   logic [SPEED_W-1:0]  prof_speed [64];
   logic [WCNT_W-1:0]   prof_wcnt [64];
   logic [WEIGHT_W-1:0] prof_weight [256];
   logic [SCNT_W-1:0]   cfg_samples;
   logic [CCNT_W-1:0]   cfg_coefs;
   logic [COEF_W-1:0]   cfg_coef [4];
   bit                  written [64];

   req_item_t pending_items[$];
   rsp_item_t expected_speeds[$];
   int errors = 0;
   int cycles = 0;
   bit feeding = 1'b0;
   bit accepted = 1'b0;
   int stall_mode = 0;
   int gap = 0;
   int rsp_gap = 0;

   task automatic report(input string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   task automatic enqueue_item(input req_item_t it);
      pending_items = {pending_items, it};
   endtask

   function automatic longint end_speed(input int idx);
      longint s;
      int n;
      longint p;
      s = prof_speed[idx];
      n = prof_wcnt[idx];
      if (n > cfg_coefs) n = cfg_coefs;
      if (n > 4) n = 4;
      for (int j = 0; j < n; j++) begin
         p = longint'($signed(prof_weight[idx*4+j])) * longint'($signed(cfg_coef[j]));
         s += p >>> 8;
      end
      return s;
   endfunction

   function automatic void apply_item(input req_item_t it);
      int n;
      longint res, up, dn, d0, d1;
      rsp_item_t r;
      case (it.mode)
         MODE_SAMPLE: begin
            prof_depth[it.entry] = it.depth;
            prof_speed[it.entry] = it.speed;
            prof_wcnt[it.entry] = it.wcnt;
         end
         MODE_WEIGHT: prof_weight[it.entry*4+it.widx] = it.wval;
         MODE_QUERY: begin
            n = (cfg_samples > 64) ? 64 : cfg_samples;
            res = 0;
            r.found = 1'b0;
            for (int i = 0; i + 1 < n; i++) begin
               d0 = prof_depth[i];
               d1 = prof_depth[i+1];
               if (it.depth >= d0 && it.depth <= d1) begin
                  up = end_speed(i);
                  dn = end_speed(i+1);
                  if (d1 == d0) res = up;
                  else res = up + ((longint'(it.depth) - d0) * (dn - up)) / (d1 - d0);
                  r.found = 1'b1;
                  break;
               end
            end
            if (res > SPEED_LIMIT) res = SPEED_LIMIT;
            if (res < -SPEED_LIMIT) res = -SPEED_LIMIT;
            r.speed = res[RES_W-1:0];
            expected_speeds = {expected_speeds, r};
         end
         default: ;
      endcase
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || accepted) begin
            if (gap > 0) begin
               gap--;
               req_valid <= 1'b0;
            end else if (feeding && pending_items.size() > 0) begin
               req_item_t it;
               it = pending_items.pop_front();
               req_mode <= it.mode;
               req_entry_index <= it.entry;
               req_weight_index <= it.widx;
               req_depth_value <= it.depth;
               req_speed_value <= it.speed;
               req_weight_count <= it.wcnt;
               req_weight_value <= it.wval;
               req_valid <= 1'b1;
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            end else
               req_valid <= 1'b0;
         end
         // wait the drawn number of cycles before taking the next result
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= 1'b1;
      end
   end

   // acceptance seen at the rising edge
   always @(posedge clock) begin
      cycles++;
      accepted <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         req_item_t it;
         it.mode = req_mode; it.entry = req_entry_index; it.widx = req_weight_index;
         it.depth = req_depth_value; it.speed = req_speed_value;
         it.wcnt = req_weight_count; it.wval = req_weight_value;
         apply_item(it);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_gap = (stall_mode == 0) ? 0 : $urandom_range(0, 11);
         if (expected_speeds.size() == 0)
            report("result with nothing expected");
         else begin
            rsp_item_t e;
            e = expected_speeds.pop_front();
            if (rsp_speed_result !== e.speed)
               report($sformatf("speed_result %0d, want %0d", rsp_speed_result, e.speed));
            if (rsp_found !== e.found)
               report($sformatf("found %0b, want %0b", rsp_found, e.found));
         end
      end
   end

   always @(posedge clock)
      if (cycles > 3000000) begin
         $display("** sound_speed_profile_interpolator: FAILED **");
         $finish;
      end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(idx) << 2; pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         CSR_SAMPLE_COUNT: cfg_samples = val[SCNT_W-1:0];
         CSR_COEF_COUNT:   cfg_coefs = val[CCNT_W-1:0];
         default:          cfg_coef[idx-CSR_COEF_ZERO] = val[COEF_W-1:0];
      endcase
   endtask

   function automatic req_item_t mk(input logic [1:0] m, input int e, input int wi,
                                    input int d, input int s, input int wc, input int wv);
      req_item_t it;
      it.mode = m; it.entry = 6'(e); it.widx = 2'(wi); it.depth = DEPTH_W'(d);
      it.speed = SPEED_W'(s); it.wcnt = WCNT_W'(wc); it.wval = WEIGHT_W'(wv);
      return it;
   endfunction

   // run queued items and wait until the block is idle again
   task automatic drain();
      feeding = 1'b1;
      while (pending_items.size() > 0 || req_valid) @(posedge clock);
      feeding = 1'b0;
      while (expected_speeds.size() > 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   // fill the first n entries with random content; depths do not fall, but the last may be set to 1100000
   task automatic load_profile(input int n, input bit dup);
      int d;
      d = $urandom_range(0, 2000);
      for (int i = 0; i < n; i++) begin
         enqueue_item(mk(MODE_SAMPLE, i, $urandom, d,
            ($urandom_range(0, 7) == 0) ? 2097151 * $urandom_range(0, 1) :
            $urandom_range(1400000, 1600000), $urandom_range(0, 7), $urandom));
         written[i] = 1'b1;
         for (int w = 0; w < 4; w++)
            enqueue_item(mk(MODE_WEIGHT, i, w, $urandom, $urandom, $urandom,
               ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4000) - 2000));
         if (!(dup && $urandom_range(0, 3) == 0))
            d += (i == n - 2 && $urandom_range(0, 1)) ? 1100000 - d : $urandom_range(1, 30000);
         if (d > 2097151) d = 2097151;
      end
   endtask

   task automatic queries(input int n, input int top);
      for (int k = 0; k < n; k++) begin
         int r;
         r = $urandom_range(0, 9);
         enqueue_item(mk((r == 0) ? 2'd3 : MODE_QUERY, $urandom, $urandom,
            (r == 1) ? $urandom : (r == 2) ? 2097151 : $urandom_range(0, top),
            $urandom, $urandom, $urandom));
      end
   endtask

   initial begin
      int total, ns;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      cfg_samples = 0; cfg_coefs = 0;
      for (int i = 0; i < 4; i++) cfg_coef[i] = 0;
      foreach (prof_depth[i]) begin
         prof_depth[i] = 0; prof_speed[i] = 0; prof_wcnt[i] = 0; written[i] = 0;
      end
      foreach (prof_weight[i]) prof_weight[i] = 0;

      // directed: empty table, extremes, mode 3, equal depths
      enqueue_item(mk(MODE_QUERY, 0, 0, 0, 0, 0, 0));
      enqueue_item(mk(MODE_SAMPLE, 0, 0, 0, 0, 4, 0));
      enqueue_item(mk(MODE_SAMPLE, 1, 3, 0, 2097151, 7, 0));
      enqueue_item(mk(MODE_SAMPLE, 2, 0, 1100000, 1500000, 2, 0));
      enqueue_item(mk(MODE_SAMPLE, 63, 0, 2097151, 2097151, 0, -1));
      enqueue_item(mk(MODE_WEIGHT, 0, 0, 0, 0, 0, 1000000));
      enqueue_item(mk(MODE_WEIGHT, 1, 3, 0, 0, 0, -1048576));
      enqueue_item(mk(MODE_WEIGHT, 2, 1, 0, 0, 0, 1048575));
      for (int w = 0; w < 4; w++) begin
         if (w != 0) enqueue_item(mk(MODE_WEIGHT, 0, w, 0, 0, 0, -w * 7777));
         if (w != 3) enqueue_item(mk(MODE_WEIGHT, 1, w, 0, 0, 0, w * 9999));
         if (w != 1) enqueue_item(mk(MODE_WEIGHT, 2, w, 0, 0, 0, 12345));
      end
      enqueue_item(mk(2'd3, 5, 1, 7, 7, 7, 7));
      for (int i = 0; i < 3; i++) written[i] = 1'b1;
      drain();
      csr_write(CSR_SAMPLE_COUNT, 3);
      csr_write(CSR_COEF_COUNT, 4);
      csr_write(CSR_COEF_ZERO, 32'h7FFF);
      csr_write(CSR_COEF_ONE, 32'h8000);
      csr_write(CSR_COEF_TWO, 32'h0100);
      csr_write(CSR_COEF_THREE, 32'hFF00);
      enqueue_item(mk(MODE_QUERY, 0, 0, 0, 0, 0, 0));
      enqueue_item(mk(MODE_QUERY, 0, 0, 550000, 0, 0, 0));
      enqueue_item(mk(MODE_QUERY, 0, 0, 1100000, 0, 0, 0));
      enqueue_item(mk(MODE_QUERY, 0, 0, 2097151, 0, 0, 0));
      drain();

      // random phases with changing settings
      total = 0;
      while (total < 700) begin
         ns = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(2, 12);
         stall_mode = $urandom_range(0, 2);
         load_profile(ns, 1'b1);
         csr_write(CSR_SAMPLE_COUNT, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) :
                   ($urandom_range(0, 5) == 0 && ns == 64) ? 127 : ns);
         csr_write(CSR_COEF_COUNT, $urandom_range(0, 7));
         for (int c = 0; c < 4; c++)
            csr_write(3'(CSR_COEF_ZERO + c), ($urandom_range(0, 4) == 0) ?
                      (($urandom_range(0, 1)) ? 32'h7FFF : 32'h8000) : $urandom);
         if (cfg_samples > ns && cfg_samples <= 64) csr_write(CSR_SAMPLE_COUNT, ns);
         if (cfg_samples > 64) for (int i = ns; i < 64; i++) if (!written[i]) ns = 0;
         if (ns == 0) csr_write(CSR_SAMPLE_COUNT, 64);
         queries(40, prof_depth[cfg_samples > 1 ? ((cfg_samples > 64 ? 64 : cfg_samples) - 1) : 0] + 100);
         total += 40 + ns * 5;
         drain();
      end

      if (errors == 0 && expected_speeds.size() == 0)
         $display("** sound_speed_profile_interpolator: PASSED **");
      else
         $display("** sound_speed_profile_interpolator: FAILED **");
      $finish;
   end
endmodule
